@@ sv/pod_pkg.sv @@
// Package for the planar odometry integrator: constants, sequencer states,
// multiplier control structs and the CORDIC arctangent table.
// No dependencies.
package pod_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MUL_W = 32;
  localparam int MUL_CNT_W = $clog2(MUL_W);

  localparam logic [15:0] STEP_TIME_RST  = 16'd2163;
  localparam logic [15:0] SPEED_GAIN_RST = 16'd1311;
  localparam logic [31:0] INV_TWO_PI_Q34  = 32'd2734261102;
  localparam logic [31:0] CORDIC_INV_GAIN = 32'd2608131496;

  typedef enum logic [1:0] {
    REG_ENABLED    = 2'd0,
    REG_STEP_TIME  = 2'd1,
    REG_SPEED_GAIN = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_GD, S_W, S_ANG, S_ROT, S_CORD, S_KX, S_KY, S_PX, S_PY, S_OUT
  } state_t;

  typedef struct packed {
    logic start;
  } mul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

  // arctangent of 2^-i in binary-angle units (full turn = 2^32)
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;  5'd31: v = 32'h00000000;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

@@ sv/pod_sermul.sv @@
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on pod_pkg.
module pod_sermul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pod_pkg::mul_ctl_t            ctl,
  input  logic [pod_pkg::MUL_W-1:0]    a,
  input  logic [pod_pkg::MUL_W-1:0]    b,
  output pod_pkg::mul_sts_t            sts,
  output logic [2*pod_pkg::MUL_W-1:0]  p
);
  localparam int W = pod_pkg::MUL_W;
  localparam int CW = pod_pkg::MUL_CNT_W;

  logic [W-1:0]   a_r, a_nxt;
  logic [2*W-1:0] p_r, p_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [W:0]     sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r <= a_nxt;
    p_r <= p_nxt;
  end

  always_comb begin
    a_nxt    = a_r;
    p_nxt    = p_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    // upper half plus multiplicand when the low bit is set, then shift right
    sum = {1'b0, p_r[2*W-1:W]} + (p_r[0] ? {1'b0, a_r} : '0);
    if (busy_r) begin
      p_nxt   = {sum, p_r[W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (ctl.start) begin
      a_nxt    = a;
      p_nxt    = {{W{1'b0}}, b};
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign p = p_r;
endmodule

@@ sv/planar_odometry_integrator.sv @@
// Planar dead-reckoning odometry: heading step, CORDIC rotation, position update.
// Depends on pod_pkg and pod_sermul.
//
//  channel  ports                                   handshake
//  in       in_fwd_speed, in_side_speed, in_turn_rate  in_valid / in_stall
//  out      out_pos_x, out_pos_y, out_heading, out_updated  out_valid / out_stall
//  cfg      psel penable pwrite paddr pwdata prdata pready  APB, pready tied high
//
// An enabled item runs seven products through the one bit-serial multiplier and
// one CORDIC step per cycle; a disabled item goes straight to the output state.
// Synchronous active-low reset clears the pose and loads register defaults.
// A new item is taken once the sequencer is idle; a stalled result holds the
// sequencer in its last state until the output register frees.
module planar_odometry_integrator #(
  parameter int CORDIC_STEPS = pod_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_fwd_speed,
  input  logic signed [15:0] in_side_speed,
  input  logic signed [15:0] in_turn_rate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic        [31:0] out_heading,
  output logic               out_updated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [3:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);
  localparam int STEPS_USED = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam logic [4:0] LAST_STEP = 5'(STEPS_USED - 1);
  localparam int W = pod_pkg::MUL_W;

  pod_pkg::state_t state_r, state_nxt;
  logic               enabled_r;
  logic [15:0]        step_time_r, speed_gain_r;
  logic signed [15:0] vx_r, vx_nxt, vy_r, vy_nxt, w_r, w_nxt;
  logic [31:0]        gd_r, gd_nxt, rad_r, rad_nxt, yaw_r, yaw_nxt;
  logic               neg_r, neg_nxt;
  logic signed [27:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [31:0] z_r, z_nxt;
  logic [4:0]         it_r, it_nxt;
  logic signed [31:0] xa_r, xa_nxt, ya_r, ya_nxt;
  logic               upd_r, upd_nxt;
  logic               ov_r, ov_nxt;
  logic signed [31:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [31:0]        oh_r, oh_nxt;
  logic               ou_r, ou_nxt;

  pod_pkg::mul_ctl_t mctl;
  pod_pkg::mul_sts_t msts;
  logic [W-1:0]   ma, mb;
  logic [2*W-1:0] mp;

  logic               wr_en;
  pod_pkg::reg_idx_t  widx;

  // combinational scratch
  logic [15:0]        wmag;
  logic [27:0]        xmag, ymag, m28;
  logic [63:0]        rnd;
  logic [31:0]        dmag;
  logic [1:0]         q;
  logic [31:0]        res;
  logic signed [27:0] xs, ys, dx, dy;
  logic signed [28:0] delta;
  logic signed [32:0] sum;
  logic               go;

  pod_sermul u_mul (
    .clk(clk), .rst_n(rst_n), .ctl(mctl), .a(ma), .b(mb), .sts(msts), .p(mp)
  );

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = pod_pkg::reg_idx_t'(paddr[3:2]);

  always_comb begin
    unique case (widx)
      pod_pkg::REG_ENABLED:    prdata = {31'b0, enabled_r};
      pod_pkg::REG_STEP_TIME:  prdata = {16'b0, step_time_r};
      pod_pkg::REG_SPEED_GAIN: prdata = {16'b0, speed_gain_r};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r    <= 1'b0;
      step_time_r  <= pod_pkg::STEP_TIME_RST;
      speed_gain_r <= pod_pkg::SPEED_GAIN_RST;
    end else if (wr_en) begin
      unique case (widx)
        pod_pkg::REG_ENABLED:    enabled_r    <= pwdata[0];
        pod_pkg::REG_STEP_TIME:  step_time_r  <= pwdata[15:0];
        pod_pkg::REG_SPEED_GAIN: speed_gain_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pod_pkg::S_IDLE;
      yaw_r   <= '0;
      xa_r    <= '0;
      ya_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      yaw_r   <= yaw_nxt;
      xa_r    <= xa_nxt;
      ya_r    <= ya_nxt;
      ov_r    <= ov_nxt;
    end
    vx_r  <= vx_nxt;  vy_r  <= vy_nxt;  w_r  <= w_nxt;
    gd_r  <= gd_nxt;  rad_r <= rad_nxt; neg_r <= neg_nxt;
    cx_r  <= cx_nxt;  cy_r  <= cy_nxt;  z_r  <= z_nxt;  it_r <= it_nxt;
    upd_r <= upd_nxt;
    ox_r  <= ox_nxt;  oy_r  <= oy_nxt;  oh_r <= oh_nxt; ou_r <= ou_nxt;
  end

  assign in_stall    = (state_r != pod_pkg::S_IDLE);
  assign out_valid   = ov_r;
  assign out_pos_x   = ox_r;
  assign out_pos_y   = oy_r;
  assign out_heading = oh_r;
  assign out_updated = ou_r;

  always_comb begin
    state_nxt = state_r;
    vx_nxt = vx_r;  vy_nxt = vy_r;  w_nxt = w_r;
    gd_nxt = gd_r;  rad_nxt = rad_r; neg_nxt = neg_r; yaw_nxt = yaw_r;
    cx_nxt = cx_r;  cy_nxt = cy_r;  z_nxt = z_r;  it_nxt = it_r;
    xa_nxt = xa_r;  ya_nxt = ya_r;  upd_nxt = upd_r;
    ox_nxt = ox_r;  oy_nxt = oy_r;  oh_nxt = oh_r; ou_nxt = ou_r;
    ov_nxt = ov_r && out_stall;
    ma = '0;
    mb = '0;
    go = !msts.busy && !msts.done;
    mctl.start = 1'b0;

    wmag = w_r[15] ? 16'(-w_r) : 16'(w_r);
    xmag = cx_r[27] ? 28'(-cx_r) : 28'(cx_r);
    ymag = cy_r[27] ? 28'(-cy_r) : 28'(cy_r);
    rnd  = mp + 64'h0000_0000_8000_0000;
    m28  = rnd[59:32];
    dmag = '0;
    q    = 2'((yaw_r + 32'h2000_0000) >> 30);
    res  = yaw_r - {q, 30'b0};
    xs   = {{4{vx_r[15]}}, vx_r, 8'b0};
    ys   = {{4{vy_r[15]}}, vy_r, 8'b0};
    dx   = cy_r >>> it_r;
    dy   = cx_r >>> it_r;
    delta = '0;
    sum   = '0;

    unique case (state_r)
      pod_pkg::S_IDLE: begin
        if (in_valid) begin
          vx_nxt  = in_fwd_speed;
          vy_nxt  = in_side_speed;
          w_nxt   = in_turn_rate;
          upd_nxt = enabled_r;
          state_nxt = enabled_r ? pod_pkg::S_GD : pod_pkg::S_OUT;
        end
      end
      pod_pkg::S_GD: begin
        ma = {16'b0, speed_gain_r};
        mb = {16'b0, step_time_r};
        mctl.start = go;
        if (msts.done) begin
          gd_nxt = mp[31:0];
          state_nxt = pod_pkg::S_W;
        end
      end
      pod_pkg::S_W: begin
        ma = {16'b0, wmag};
        mb = gd_r;
        mctl.start = go;
        if (msts.done) begin
          rnd = mp + 64'h8000;
          rad_nxt = rnd[47:16];
          neg_nxt = w_r[15];
          state_nxt = pod_pkg::S_ANG;
        end
      end
      pod_pkg::S_ANG: begin
        ma = rad_r;
        mb = pod_pkg::INV_TWO_PI_Q34;
        mctl.start = go;
        if (msts.done) begin
          rnd  = mp + 64'h0200_0000;
          dmag = rnd[57:26];
          yaw_nxt = neg_r ? yaw_r - dmag : yaw_r + dmag;
          state_nxt = pod_pkg::S_ROT;
        end
      end
      pod_pkg::S_ROT: begin
        // exact quarter turn first, the rest is within +-45 degrees
        unique case (q)
          2'd0: begin cx_nxt = xs;  cy_nxt = ys;  end
          2'd1: begin cx_nxt = -ys; cy_nxt = xs;  end
          2'd2: begin cx_nxt = -xs; cy_nxt = -ys; end
          default: begin cx_nxt = ys; cy_nxt = -xs; end
        endcase
        z_nxt  = res;
        it_nxt = '0;
        state_nxt = pod_pkg::S_CORD;
      end
      pod_pkg::S_CORD: begin
        if (!z_r[31]) begin
          cx_nxt = cx_r - dx;
          cy_nxt = cy_r + dy;
          z_nxt  = z_r - pod_pkg::atan_entry(it_r);
        end else begin
          cx_nxt = cx_r + dx;
          cy_nxt = cy_r - dy;
          z_nxt  = z_r + pod_pkg::atan_entry(it_r);
        end
        it_nxt = it_r + 1'b1;
        if (it_r == LAST_STEP) state_nxt = pod_pkg::S_KX;
      end
      pod_pkg::S_KX: begin
        ma = {4'b0, xmag};
        mb = pod_pkg::CORDIC_INV_GAIN;
        mctl.start = go;
        if (msts.done) begin
          cx_nxt = cx_r[27] ? -$signed(m28) : $signed(m28);
          state_nxt = pod_pkg::S_KY;
        end
      end
      pod_pkg::S_KY: begin
        ma = {4'b0, ymag};
        mb = pod_pkg::CORDIC_INV_GAIN;
        mctl.start = go;
        if (msts.done) begin
          cy_nxt = cy_r[27] ? -$signed(m28) : $signed(m28);
          state_nxt = pod_pkg::S_PX;
        end
      end
      pod_pkg::S_PX: begin
        ma = {4'b0, xmag};
        mb = gd_r;
        mctl.start = go;
        if (msts.done) begin
          delta = cx_r[27] ? -$signed({1'b0, m28}) : $signed({1'b0, m28});
          sum = 33'(xa_r) + 33'(delta);
          if (sum[32] != sum[31]) xa_nxt = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          else xa_nxt = sum[31:0];
          state_nxt = pod_pkg::S_PY;
        end
      end
      pod_pkg::S_PY: begin
        ma = {4'b0, ymag};
        mb = gd_r;
        mctl.start = go;
        if (msts.done) begin
          delta = cy_r[27] ? -$signed({1'b0, m28}) : $signed({1'b0, m28});
          sum = 33'(ya_r) + 33'(delta);
          if (sum[32] != sum[31]) ya_nxt = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          else ya_nxt = sum[31:0];
          state_nxt = pod_pkg::S_OUT;
        end
      end
      pod_pkg::S_OUT: begin
        if (!ov_r || !out_stall) begin
          ox_nxt = xa_r;
          oy_nxt = ya_r;
          oh_nxt = yaw_r;
          ou_nxt = upd_r;
          ov_nxt = 1'b1;
          state_nxt = pod_pkg::S_IDLE;
        end
      end
      default: state_nxt = pod_pkg::S_IDLE;
    endcase
  end
endmodule

@@ tb/sv/tb_planar_odometry_integrator.sv @@
// Testbench for planar_odometry_integrator: random and directed odometry ticks,
// APB register writes between phases, self-checking against a local pose predictor.
// Depends on pod_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_planar_odometry_integrator;

  typedef struct packed {
    logic signed [15:0] fwd;
    logic signed [15:0] side;
    logic signed [15:0] turn;
  } tick_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic        [31:0] hdg;
    logic               upd;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_fwd_speed = '0, in_side_speed = '0, in_turn_rate = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y;
  logic [31:0] out_heading;
  logic out_updated;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  planar_odometry_integrator dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic        en_r;
  logic [15:0] dt_r, gain_r;
  logic signed [63:0] x_r, y_r;
  logic [31:0] yaw_r;

  tick_t tick_q[$];
  pose_t pose_q[$];
  int    errors = 0;
  int    n_out = 0;
  int    n_upd = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;

  function automatic logic signed [63:0] rnd_shr(logic signed [63:0] v, int s);
    logic [63:0] m;
    m = v[63] ? -v : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // atan values from the package; the CORDIC itself is done locally
  task automatic rotate_vel(inout logic signed [63:0] vx, inout logic signed [63:0] vy,
                            input logic [31:0] ang);
    logic [1:0] q;
    logic [31:0] rem;
    logic signed [63:0] z, t, dx, dy;
    q = 2'((ang + 32'h20000000) >> 30);
    rem = ang - {q, 30'd0};
    z = $signed({{32{rem[31]}}, rem});
    case (q)
      2'd1: begin t = vx; vx = -vy; vy = t; end
      2'd2: begin vx = -vx; vy = -vy; end
      2'd3: begin t = vx; vx = vy; vy = -t; end
      default: ;
    endcase
    for (int i = 0; i < pod_pkg::CORDIC_STEPS_DEF && i < 32; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (z >= 0) begin
        vx -= dx; vy += dy; z -= $signed({32'd0, pod_pkg::atan_entry(5'(i))});
      end else begin
        vx += dx; vy -= dy; z += $signed({32'd0, pod_pkg::atan_entry(5'(i))});
      end
    end
    vx = rnd_shr(vx * $signed({32'd0, pod_pkg::CORDIC_INV_GAIN}), 32);
    vy = rnd_shr(vy * $signed({32'd0, pod_pkg::CORDIC_INV_GAIN}), 32);
  endtask

  task automatic predict_pose(input tick_t tk);
    pose_t p;
    logic signed [63:0] gd, rad, dang, wx, wy;
    p.upd = en_r;
    if (en_r) begin
      gd = $signed({48'd0, gain_r}) * $signed({48'd0, dt_r});
      rad = rnd_shr(64'(tk.turn) * gd, 16);
      dang = rnd_shr(rad * $signed({32'd0, pod_pkg::INV_TWO_PI_Q34}), 26);
      yaw_r = yaw_r + dang[31:0];
      wx = 64'(tk.fwd) * 256;
      wy = 64'(tk.side) * 256;
      rotate_vel(wx, wy, yaw_r);
      x_r = sat32(x_r + rnd_shr(wx * gd, 32));
      y_r = sat32(y_r + rnd_shr(wy * gd, 32));
    end
    p.px = x_r[31:0];
    p.py = y_r[31:0];
    p.hdg = yaw_r;
    pose_q.push_back(p);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, n_out);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (tick_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_fwd_speed <= tick_q[0].fwd;
          in_side_speed <= tick_q[0].side;
          in_turn_rate <= tick_q[0].turn;
          in_valid <= 1'b1;
          void'(tick_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    pose_t w;
    if (rst_n) begin
      if (in_valid && !in_stall)
        predict_pose('{in_fwd_speed, in_side_speed, in_turn_rate});
      if (out_valid && !out_stall) begin
        n_out++;
        if (out_updated) n_upd++;
        if (pose_q.size() == 0) begin
          report_mismatch("unexpected result", out_pos_x, 32'd0);
        end else begin
          w = pose_q.pop_front();
          if (out_pos_x !== w.px) report_mismatch("pos_x", out_pos_x, w.px);
          if (out_pos_y !== w.py) report_mismatch("pos_y", out_pos_y, w.py);
          if (out_heading !== w.hdg) report_mismatch("heading", out_heading, w.hdg);
          if (out_updated !== w.upd)
            report_mismatch("updated", 32'(out_updated), 32'(w.upd));
        end
      end
    end
  end

  task automatic cfg_write(input pod_pkg::reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 4'(idx) << 2; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      pod_pkg::REG_ENABLED:    en_r = val[0];
      pod_pkg::REG_STEP_TIME:  dt_r = val[15:0];
      pod_pkg::REG_SPEED_GAIN: gain_r = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tick_q.size() > 0 || in_valid || pose_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rnd_speed();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(16'($urandom));
      3: return 16'sd0;
      default: return 16'($signed(17'($urandom_range(51200)) - 17'sd25600));
    endcase
  endfunction

  task automatic add_random(input int n);
    repeat (n) tick_q.push_back('{rnd_speed(), rnd_speed(), rnd_speed()});
  endtask

  initial begin
    en_r = 1'b0; dt_r = pod_pkg::STEP_TIME_RST; gain_r = pod_pkg::SPEED_GAIN_RST;
    x_r = 0; y_r = 0; yaw_r = 0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // disabled ticks change nothing
    tick_q.push_back('{16'sd25600, -16'sd25600, 16'sd100});
    tick_q.push_back('{16'sh7FFF, 16'sh8000, 16'sh7FFF});
    wait_drained();
    cfg_write(pod_pkg::REG_ENABLED, 32'd1);
    // directed: extremes, zero, large turn rates
    tick_q.push_back('{16'sd0, 16'sd0, 16'sd0});
    tick_q.push_back('{16'sd25600, 16'sd0, 16'sd0});
    tick_q.push_back('{-16'sd25600, 16'sd25600, 16'sd25600});
    tick_q.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
    tick_q.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
    tick_q.push_back('{16'sd0, 16'sd256, -16'sd25600});
    tick_q.push_back('{16'sh5555, 16'shAAAA, 16'shAAAA});
    tick_q.push_back('{16'shAAAA, 16'sh5555, 16'sh5555});
    wait_drained();
    // big dt and gain: fast turning and position saturation
    cfg_write(pod_pkg::REG_STEP_TIME, 32'hFFFF);
    cfg_write(pod_pkg::REG_SPEED_GAIN, 32'hFFFF);
    repeat (6) tick_q.push_back('{16'sh7FFF, 16'sd0, 16'sh1234});
    repeat (6) tick_q.push_back('{16'sh8000, 16'sh8000, 16'sh7FFF});
    wait_drained();
    cfg_write(pod_pkg::REG_NONE, 32'hFFFF_FFFF);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      case (ph)
        1: cfg_write(pod_pkg::REG_STEP_TIME, 32'd0);
        2: begin
          cfg_write(pod_pkg::REG_STEP_TIME, 32'($urandom));
          cfg_write(pod_pkg::REG_SPEED_GAIN, 32'd0);
        end
        3: cfg_write(pod_pkg::REG_SPEED_GAIN, 32'($urandom));
        4: cfg_write(pod_pkg::REG_ENABLED, 32'd0);
        5: begin
          cfg_write(pod_pkg::REG_ENABLED, 32'd1);
          cfg_write(pod_pkg::REG_STEP_TIME, 32'(pod_pkg::STEP_TIME_RST));
          cfg_write(pod_pkg::REG_SPEED_GAIN, 32'(pod_pkg::SPEED_GAIN_RST));
        end
        6: cfg_write(pod_pkg::REG_SPEED_GAIN, 32'hFFFF);
        7: cfg_write(pod_pkg::REG_STEP_TIME, 32'($urandom_range(4000)));
        default: ;
      endcase
      add_random(ph == 4 ? 60 : 175);
      wait_drained();
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    $display("Checked %0d results (%0d integrated) over several gain, dt and stall phases.",
             n_out, n_upd);
    if (errors == 0)
      $display("planar_odometry_integrator test passed");
    else
      $display("planar_odometry_integrator test failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("Timeout with %0d results pending", pose_q.size());
    $display("planar_odometry_integrator test failed");
    $finish;
  end
endmodule
